// ----- rtl/lraa_pkg.sv -----
`timescale 1ns / 1ps

package lraa_pkg;

  localparam int unsigned StepPeriodW = 10;
  localparam int unsigned FlashPeriodW = 14;
  localparam int unsigned WindowW = 14;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CountW = 16;
  localparam int unsigned LedOutW = 8;

  localparam logic [StepPeriodW-1:0] StepPeriodReset = 10'd120;
  localparam logic [FlashPeriodW-1:0] FlashPeriodReset = 14'd800;
  localparam logic [WindowW-1:0] WindowReset = 14'd1000;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_STEP_PERIOD = 2'd0,
    CFG_FLASH_PERIOD = 2'd1,
    CFG_RECENT_WINDOW = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    MODE_BOUNCE = 2'd0,
    MODE_SWEEP = 2'd1,
    MODE_FLASH = 2'd2
  } mode_e;

  typedef struct packed {
    logic [StepPeriodW-1:0] step_period;
    logic [FlashPeriodW-1:0] flash_period;
    logic [WindowW-1:0] recent_window;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic byte_valid;
    logic queue_pending;
  } item_t;

endpackage

// ----- rtl/lraa_engine.sv -----
`timescale 1ns / 1ps

module lraa_engine #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  lraa_pkg::item_t                item_i,
  input  lraa_pkg::cfg_t                 cfg_i,
  output logic [lraa_pkg::LedOutW-1:0]   led_on_o,
  output lraa_pkg::mode_e                mode_o
);
  import lraa_pkg::*;

  localparam int unsigned PosW = $clog2(LED_COUNT);
  localparam logic [PosW-1:0] Top = PosW'(LED_COUNT - 1);

  logic              seen_q, seen_d;
  logic [CountW-1:0] since_q, since_d;
  logic [CountW-1:0] step_q, step_d;
  logic [CountW-1:0] flash_q, flash_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              up_q, up_d;
  logic              lit_q, lit_d;
  logic              paused_q, paused_d;
  logic [CountW-1:0] pause_q, pause_d;

  logic [CountW-1:0] since_t, step_t, flash_t, pause_t;
  logic              active, recent, step_hit, pause_done, paused_eff;
  logic [PosW-1:0]   pos_eff, pos_inc;
  logic [CountW-1:0] pause_len;
  logic [LED_COUNT-1:0] spot;
  logic [LED_COUNT+LedOutW-1:0] spot_ext, row_ext;

  assign since_t = (item_i.tick && since_q != CountMax) ? since_q + 1'b1 : since_q;
  assign step_t = (item_i.tick && step_q != CountMax) ? step_q + 1'b1 : step_q;
  assign flash_t = (item_i.tick && flash_q != CountMax) ? flash_q + 1'b1 : flash_q;
  assign pause_t = (item_i.tick && pause_q != '0) ? pause_q - 1'b1 : pause_q;

  assign seen_d = seen_q | item_i.byte_valid;
  assign since_d = item_i.byte_valid ? '0 : since_t;
  assign active = item_i.queue_pending | seen_d;
  assign recent = since_d <= {{(CountW - WindowW){1'b0}}, cfg_i.recent_window};
  assign step_hit = step_t >= {{(CountW - StepPeriodW){1'b0}}, cfg_i.step_period};

  assign pause_done = paused_q && (pause_t == '0);
  assign paused_eff = paused_q && !pause_done;
  assign pos_eff = pause_done ? '0 : pos_q;
  assign pos_inc = (pos_eff < Top) ? pos_eff + 1'b1 : pos_eff;
  assign pause_len = CountW'(CountW'(LED_COUNT - 1) * CountW'(cfg_i.step_period));

  always_comb begin
    step_d = step_t;
    flash_d = flash_t;
    pos_d = pos_q;
    up_d = up_q;
    lit_d = lit_q;
    paused_d = paused_q;
    pause_d = pause_t;
    mode_o = MODE_FLASH;
    if (active && recent) begin
      mode_o = MODE_BOUNCE;
      if (step_hit) begin
        step_d = '0;
        if (up_q) begin
          if (pos_q >= Top) begin
            up_d = 1'b0;
            pos_d = Top - 1'b1;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end else begin
          if (pos_q == '0) begin
            up_d = 1'b1;
            pos_d = PosW'(1);
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
    end else if (active) begin
      mode_o = MODE_SWEEP;
      paused_d = paused_eff;
      pos_d = pos_eff;
      if (!paused_eff && step_hit) begin
        step_d = '0;
        pos_d = pos_inc;
        if (pos_inc >= Top) begin
          paused_d = 1'b1;
          pause_d = pause_len;
        end
      end
    end else begin
      if (flash_t >= {{(CountW - FlashPeriodW){1'b0}}, cfg_i.flash_period}) begin
        flash_d = '0;
        lit_d = !lit_q;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      if (pos_d == '0) begin
        spot[i] = (i == 0);
      end else if (pos_d >= Top) begin
        spot[i] = (PosW'(i) == Top);
      end else begin
        spot[i] = (PosW'(i) == pos_d) || (PosW'(i) == pos_d - 1'b1);
      end
    end
  end

  assign spot_ext = {{LedOutW{1'b0}}, spot};
  assign row_ext = {{LedOutW{1'b0}}, {LED_COUNT{lit_d}}};
  assign led_on_o = (mode_o == MODE_FLASH) ? row_ext[LedOutW-1:0] : spot_ext[LedOutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      since_q <= CountMax;
      step_q <= '0;
      flash_q <= '0;
      pos_q <= '0;
      up_q <= 1'b1;
      lit_q <= 1'b0;
      paused_q <= 1'b0;
      pause_q <= '0;
    end else if (advance_i) begin
      seen_q <= seen_d;
      since_q <= since_d;
      step_q <= step_d;
      flash_q <= flash_d;
      pos_q <= pos_d;
      up_q <= up_d;
      lit_q <= lit_d;
      paused_q <= paused_d;
      pause_q <= pause_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= Top)
    else $error("Spot position beyond the top LED.");

  a_byte_sets_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.byte_valid |=> seen_q)
    else $error("Received byte did not set the seen flag.");

  a_step_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.tick && step_q != CountMax |=>
      (step_q == '0) || (step_q == $past(step_q) + 1'b1))
    else $error("Step counter neither advanced nor cleared on a tick.");
`endif

endmodule

// ----- rtl/led_row_activity_animator_core.sv -----
`timescale 1ns / 1ps

// Activity animator for a row of LED_COUNT LEDs; led_on_o shows the low eight.
// One beat is accepted every clock cycle while the output is not stalled; each
// beat is held in an input register while the animation state updates, and
// its result is registered in the output register once the output is free.
// The user must write registers through the cfg channel only while no beat is
// in flight; the block itself does not enforce this.

module led_row_activity_animator_core #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lraa_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [lraa_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              tick_i,
  input  logic                              byte_valid_i,
  input  logic                              queue_pending_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lraa_pkg::LedOutW-1:0]      led_on_o,
  output logic [1:0]                        mode_o
);
  import lraa_pkg::*;

  cfg_t  cfg_q;
  item_t item_q;
  logic  in_valid_q, out_valid_q;
  logic  out_free, advance, in_accept;
  logic [LedOutW-1:0] led_d, led_q;
  mode_e mode_d, mode_q;

  assign cfg_ready_o = 1'b1;
  assign out_free = !out_valid_q || out_ready_i;
  assign advance = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_period <= StepPeriodReset;
      cfg_q.flash_period <= FlashPeriodReset;
      cfg_q.recent_window <= WindowReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STEP_PERIOD: cfg_q.step_period <= cfg_data_i[StepPeriodW-1:0];
        CFG_FLASH_PERIOD: cfg_q.flash_period <= cfg_data_i[FlashPeriodW-1:0];
        CFG_RECENT_WINDOW: cfg_q.recent_window <= cfg_data_i[WindowW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{tick: tick_i, byte_valid: byte_valid_i, queue_pending: queue_pending_i};
    end
    if (advance) begin
      led_q <= led_d;
      mode_q <= mode_d;
    end
  end

  lraa_engine #(
    .LED_COUNT(LED_COUNT)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .advance_i(advance),
    .item_i(item_q),
    .cfg_i(cfg_q),
    .led_on_o(led_d),
    .mode_o(mode_d)
  );

  assign out_valid_o = out_valid_q;
  assign led_on_o = led_q;
  assign mode_o = mode_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("Input stalled while the pipeline had room.");

  a_result_from_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("Result appeared without a beat moving forward.");

  a_held_beat_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_free |=> !in_valid_q || $past(in_accept))
    else $error("Held beat was not moved forward while the output was free.");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import lraa_pkg::*;

  localparam int unsigned LedCount = 8;
  localparam logic [2:0] TopPos = 3'(LedCount - 1);
  localparam logic [CfgIndexW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [LedOutW-1:0] led;
    mode_e mode;
  } led_result_t;

  class led_row_scoreboard;
    logic [StepPeriodW-1:0] step_period;
    logic [FlashPeriodW-1:0] flash_period;
    logic [WindowW-1:0] recent_window;
    bit seen_input;
    logic [CountW-1:0] since_byte;
    logic [CountW-1:0] step_count;
    logic [CountW-1:0] flash_count;
    logic [CountW-1:0] pause_left;
    logic [2:0] position;
    bit moving_up;
    bit flash_lit;
    bit sweep_paused;
    led_result_t expected[$];
    int mismatches;

    function new();
      step_period = StepPeriodReset;
      flash_period = FlashPeriodReset;
      recent_window = WindowReset;
      seen_input = 1'b0;
      since_byte = CountMax;
      step_count = '0;
      flash_count = '0;
      pause_left = '0;
      position = '0;
      moving_up = 1'b1;
      flash_lit = 1'b0;
      sweep_paused = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_STEP_PERIOD: step_period = data[StepPeriodW-1:0];
        CFG_FLASH_PERIOD: flash_period = data;
        CFG_RECENT_WINDOW: recent_window = data;
        default: ;
      endcase
    endfunction

    function bit step_due();
      if (step_count >= CountW'(step_period)) begin
        step_count = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [LedOutW-1:0] spot_leds();
      logic [LedOutW-1:0] m;
      if (position == 3'd0) m = 8'd1;
      else if (position >= TopPos) m = 8'd1 << TopPos;
      else m = (8'd1 << (position - 3'd1)) | (8'd1 << position);
      return m;
    endfunction

    function void note_input(bit tick, bit byte_in, bit pending);
      led_result_t res;
      bit active;
      if (tick) begin
        if (since_byte != CountMax) since_byte++;
        if (step_count != CountMax) step_count++;
        if (flash_count != CountMax) flash_count++;
        if (pause_left != '0) pause_left--;
      end
      if (byte_in) begin
        seen_input = 1'b1;
        since_byte = '0;
      end
      active = pending || seen_input;
      if (active && since_byte <= CountW'(recent_window)) begin
        if (step_due()) begin
          if (moving_up) begin
            if (position >= TopPos) begin
              moving_up = 1'b0;
              position = TopPos - 3'd1;
            end else begin
              position++;
            end
          end else begin
            if (position == 3'd0) begin
              moving_up = 1'b1;
              position = 3'd1;
            end else begin
              position--;
            end
          end
        end
        res.led = spot_leds();
        res.mode = MODE_BOUNCE;
      end else if (active) begin
        if (sweep_paused && pause_left == '0) begin
          sweep_paused = 1'b0;
          position = '0;
        end
        if (!sweep_paused) begin
          if (step_due()) begin
            if (position < TopPos) position++;
            if (position >= TopPos) begin
              sweep_paused = 1'b1;
              pause_left = CountW'(TopPos) * CountW'(step_period);
            end
          end
        end
        res.led = spot_leds();
        res.mode = MODE_SWEEP;
      end else begin
        if (flash_count >= CountW'(flash_period)) begin
          flash_count = '0;
          flash_lit = !flash_lit;
        end
        res.led = flash_lit ? 8'hFF : 8'h00;
        res.mode = MODE_FLASH;
      end
      expected.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] error: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [LedOutW-1:0] led, logic [1:0] mode);
      led_result_t want;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("unexpected beat led_on=%h mode=%0d", led, mode));
      end else begin
        want = expected.pop_front();
        if (led !== want.led)
          report_mismatch($sformatf("led_on got %h want %h", led, want.led));
        if (mode !== want.mode)
          report_mismatch($sformatf("mode got %0d want %0d", mode, want.mode));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic tick_i;
  logic byte_valid_i;
  logic queue_pending_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [LedOutW-1:0] led_on_o;
  logic [1:0] mode_o;

  led_row_scoreboard sb;
  bit no_idle;
  bit hold_req;

  led_row_activity_animator_core #(
    .LED_COUNT(LedCount)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .tick_i(tick_i),
    .byte_valid_i(byte_valid_i),
    .queue_pending_i(queue_pending_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .led_on_o(led_on_o),
    .mode_o(mode_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("led_row_activity_animator_core: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(led_on_o, mode_o);
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        hold_req = 1'b0;
        repeat (99) @(negedge clk_i);
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(input bit t, input bit b, input bit q);
    int gap;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    tick_i <= t;
    byte_valid_i <= b;
    queue_pending_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(t, b, q);
  endtask

  task automatic send_random(input int tick_pct, input int byte_pct, input int pend_pct);
    send_item($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < byte_pct,
              $urandom_range(0, 99) < pend_pct);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CfgDataW-1:0] step_val;
    logic [CfgDataW-1:0] window_val;
    int tick_pct;
    int byte_pct;
    sb = new();
    no_idle = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    tick_i = 1'b0;
    byte_valid_i = 1'b0;
    queue_pending_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // No byte may arrive before the idle flash has been covered, since the
    // seen flag is sticky until reset.
    send_item(1'b0, 1'b0, 1'b0);
    send_item(1'b1, 1'b0, 1'b0);
    send_item(1'b1, 1'b0, 1'b1);
    send_item(1'b0, 1'b0, 1'b1);
    drain();
    write_cfg(CFG_FLASH_PERIOD, '0);
    write_cfg(CFG_STEP_PERIOD, '0);
    repeat (2) send_item(1'b0, 1'b0, 1'b0);
    repeat (9) send_item(1'b0, 1'b0, 1'b1);
    drain();
    write_cfg(CFG_STEP_PERIOD, 14'h3FFF);
    write_cfg(CFG_FLASH_PERIOD, 14'h3FFF);
    write_cfg(CFG_RECENT_WINDOW, 14'h3FFF);
    write_cfg(CfgUnused, 14'h3FFF);
    send_item(1'b1, 1'b0, 1'b1);
    send_item(1'b1, 1'b0, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: write_cfg(CFG_FLASH_PERIOD, 14'd1);
        1: write_cfg(CFG_FLASH_PERIOD, 14'($urandom_range(2, 6)));
        default: write_cfg(CFG_FLASH_PERIOD, '0);
      endcase
      write_cfg(CFG_STEP_PERIOD, 14'($urandom_range(0, 3)));
      repeat (150) send_random(70, 0, 40);
    end

    drain();
    write_cfg(CFG_RECENT_WINDOW, '0);
    write_cfg(CFG_STEP_PERIOD, 14'd1);
    send_item(1'b0, 1'b1, 1'b0);
    send_item(1'b1, 1'b1, 1'b1);
    send_item(1'b1, 1'b0, 1'b0);
    send_item(1'b0, 1'b1, 1'b1);
    send_item(1'b1, 1'b0, 1'b1);

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      if (ph == 0) begin
        step_val = '0;
        window_val = '0;
      end else if (ph == 1) begin
        step_val = 14'h3FF;
        window_val = 14'h3FFF;
      end else begin
        case ($urandom_range(0, 5))
          0: step_val = '0;
          1: step_val = 14'h3FF;
          2: step_val = 14'($urandom_range(1024, 16383));
          default: step_val = 14'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 4))
          0: window_val = '0;
          1: window_val = 14'h3FFF;
          default: window_val = 14'($urandom_range(1, 15));
        endcase
      end
      write_cfg(CFG_STEP_PERIOD, step_val);
      write_cfg(CFG_RECENT_WINDOW, window_val);
      write_cfg(CFG_FLASH_PERIOD, 14'($urandom_range(0, 16383)));
      if (ph == 2) hold_req = 1'b1;
      if (ph == 8) no_idle = 1'b1;
      tick_pct = $urandom_range(50, 95);
      byte_pct = $urandom_range(1, 8);
      repeat (140) send_random(tick_pct, byte_pct, 50);
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected.size() == 0) begin
      $display("led_row_activity_animator_core: match");
    end else begin
      $display("led_row_activity_animator_core: mismatch");
    end
    $finish;
  end

endmodule
